// ----- hw/rtl/i2p_pkg.sv -----
package i2p_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  // power of two, at least 2
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_POW   = 8'h5E;  // '^'
  localparam logic [7:0] CH_MUL   = 8'h2A;  // '*'
  localparam logic [7:0] CH_DIV   = 8'h2F;  // '/'
  localparam logic [7:0] CH_ADD   = 8'h2B;  // '+'
  localparam logic [7:0] CH_SUB   = 8'h2D;  // '-'
  localparam logic [7:0] CH_OPEN  = 8'h28;  // '('
  localparam logic [7:0] CH_CLOSE = 8'h29;  // ')'
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_DIG_0 = 8'h30;
  localparam logic [7:0] CH_DIG_9 = 8'h39;
  localparam logic [7:0] CH_TERM  = 8'h00;

  typedef enum logic [2:0] {
    SYM_OPEN = 3'd0,
    SYM_POW  = 3'd1,
    SYM_MUL  = 3'd2,
    SYM_DIV  = 3'd3,
    SYM_ADD  = 3'd4,
    SYM_SUB  = 3'd5
  } sym_t;

  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_CHAR  = 3'd1,
    KIND_OPEN  = 3'd2,
    KIND_CLOSE = 3'd3,
    KIND_OP    = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    sym_t       op;
    logic [7:0] ch;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             busy;
  } stat_t;

  function automatic logic [7:0] sym_char(input sym_t s);
    logic [7:0] c;
    case (s)
      SYM_OPEN: c = CH_OPEN;
      SYM_POW:  c = CH_POW;
      SYM_MUL:  c = CH_MUL;
      SYM_DIV:  c = CH_DIV;
      SYM_ADD:  c = CH_ADD;
      SYM_SUB:  c = CH_SUB;
      default:  c = CH_TERM;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] sym_prec(input sym_t s);
    logic [1:0] p;
    case (s)
      SYM_POW:          p = 2'd3;
      SYM_MUL, SYM_DIV: p = 2'd2;
      SYM_ADD, SYM_SUB: p = 2'd1;
      default:          p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

// ----- hw/rtl/i2p_front.sv -----
module i2p_front
  import i2p_pkg::*;
(
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // in_char
  input  logic       s_axis_tlast,   // end_of_input
  input  logic       q_full,
  output logic       wr_valid,
  output cmd_t       wr_cmd
);

  logic [7:0] c;
  logic       alnum;

  assign c     = s_axis_tdata;
  assign alnum = (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z) ||
                 (c >= CH_DIG_0 && c <= CH_DIG_9);

  assign s_axis_tready = !q_full;
  assign wr_valid      = s_axis_tvalid && !q_full;

  always_comb begin
    wr_cmd.ch   = c;
    wr_cmd.last = s_axis_tlast;
    wr_cmd.op   = SYM_OPEN;
    wr_cmd.kind = KIND_NONE;
    if (alnum) begin
      wr_cmd.kind = KIND_CHAR;
    end else begin
      case (c)
        CH_OPEN:  wr_cmd.kind = KIND_OPEN;
        CH_CLOSE: wr_cmd.kind = KIND_CLOSE;
        CH_POW: begin
          wr_cmd.kind = KIND_OP;
          wr_cmd.op   = SYM_POW;
        end
        CH_MUL: begin
          wr_cmd.kind = KIND_OP;
          wr_cmd.op   = SYM_MUL;
        end
        CH_DIV: begin
          wr_cmd.kind = KIND_OP;
          wr_cmd.op   = SYM_DIV;
        end
        CH_ADD: begin
          wr_cmd.kind = KIND_OP;
          wr_cmd.op   = SYM_ADD;
        end
        CH_SUB: begin
          wr_cmd.kind = KIND_OP;
          wr_cmd.op   = SYM_SUB;
        end
        default: wr_cmd.kind = KIND_NONE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/i2p_cmd_fifo.sv -----
module i2p_cmd_fifo
  import i2p_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  input  cmd_t wr_cmd,
  output logic full,
  output logic rd_valid,
  input  logic rd_ready,
  output cmd_t rd_cmd
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              wr_en;
  logic              rd_en;

  assign full     = fill == QCNT_W'(QUEUE_DEPTH);
  assign rd_valid = fill != '0;
  assign rd_cmd   = entries[rd_ptr];
  assign wr_en    = wr_valid && !full;
  assign rd_en    = rd_ready && rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        fill <= fill + QCNT_W'(1);
      end else if (rd_en && !wr_en) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/i2p_back.sv -----
module i2p_back
  import i2p_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  cmd_t       cmd,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // out_char
  output logic       m_axis_tlast,   // run_last
  output logic [1:0] m_axis_tuser,   // [0] expression_done, [1] stack_overflow
  output stat_t      stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLOSE,
    S_OP,
    S_FLUSH
  } state_t;

  state_t           state;
  state_t           state_next;
  sym_t             stack_mem [STACK_DEPTH];
  sym_t             top;
  sym_t             below;
  sym_t             cur_op;
  logic             cur_last;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W-1:0] cnt_m2;
  logic             ovf;
  logic             can_go;
  logic             nonempty;
  logic             full;

  logic             do_emit;
  logic [7:0]       emit_char;
  logic             emit_last;
  logic             emit_done;
  logic             do_pop;
  logic             do_push;
  sym_t             push_sym;
  logic             take_cmd;

  assign cnt_m1   = count - CNT_W'(1);
  assign cnt_m2   = count - CNT_W'(2);
  assign below    = stack_mem[cnt_m2[IDX_W-1:0]];
  assign can_go   = !m_axis_tvalid || m_axis_tready;
  assign nonempty = count != '0;
  assign full     = count == CNT_W'(STACK_DEPTH);

  assign cmd_ready = take_cmd;
  assign stat.count = count;
  assign stat.busy  = state != S_IDLE;

  always_comb begin
    state_next = state;
    do_emit    = 1'b0;
    emit_char  = top == SYM_OPEN ? CH_OPEN : sym_char(top);
    emit_last  = 1'b0;
    emit_done  = 1'b0;
    do_pop     = 1'b0;
    do_push    = 1'b0;
    push_sym   = cmd.op;
    take_cmd   = 1'b0;
    if (can_go) begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            take_cmd = 1'b1;
            case (cmd.kind)
              KIND_CHAR: begin
                do_emit   = 1'b1;
                emit_char = cmd.ch;
                emit_last = !cmd.last;
                if (cmd.last) begin
                  state_next = S_FLUSH;
                end
              end
              KIND_OPEN: begin
                do_push  = 1'b1;
                push_sym = SYM_OPEN;
                if (cmd.last) begin
                  state_next = S_FLUSH;
                end
              end
              KIND_CLOSE: state_next = S_CLOSE;
              KIND_OP:    state_next = S_OP;
              default: begin
                if (cmd.last) begin
                  state_next = S_FLUSH;
                end
              end
            endcase
          end
        end
        S_CLOSE: begin
          if (nonempty && top != SYM_OPEN) begin
            do_pop    = 1'b1;
            do_emit   = 1'b1;
            emit_last = !cur_last && (count == CNT_W'(1) || below == SYM_OPEN);
          end else begin
            // discard the matching '(' if there is one
            do_pop     = nonempty;
            state_next = cur_last ? S_FLUSH : S_IDLE;
          end
        end
        S_OP: begin
          if (nonempty && top != SYM_OPEN && sym_prec(top) >= sym_prec(cur_op)) begin
            do_pop    = 1'b1;
            do_emit   = 1'b1;
            emit_last = !cur_last && (count == CNT_W'(1) || below == SYM_OPEN ||
                                      sym_prec(below) < sym_prec(cur_op));
          end else begin
            do_push    = 1'b1;
            push_sym   = cur_op;
            state_next = cur_last ? S_FLUSH : S_IDLE;
          end
        end
        S_FLUSH: begin
          do_emit = 1'b1;
          if (nonempty) begin
            do_pop = 1'b1;
          end else begin
            emit_char  = CH_TERM;
            emit_last  = 1'b1;
            emit_done  = 1'b1;
            state_next = S_IDLE;
          end
        end
        default: state_next = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push && !full && nonempty) begin
      stack_mem[cnt_m1[IDX_W-1:0]] <= top;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      ovf           <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (do_emit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (do_pop) begin
        count <= cnt_m1;
      end else if (do_push && !full) begin
        count <= count + CNT_W'(1);
      end
      if (do_push && full) begin
        ovf <= 1'b1;
      end else if (emit_done) begin
        ovf <= 1'b0;
      end
    end
    // payload
    if (take_cmd) begin
      cur_op   <= cmd.op;
      cur_last <= cmd.last;
    end
    if (do_pop) begin
      top <= below;
    end else if (do_push && !full) begin
      top <= push_sym;
    end
    if (do_emit) begin
      m_axis_tdata    <= emit_char;
      m_axis_tlast    <= emit_last;
      m_axis_tuser[0] <= emit_done;
      m_axis_tuser[1] <= ovf;
    end
  end

endmodule

// ----- hw/rtl/infix_to_postfix_converter_unit.sv -----
// Infix to postfix converter (shunting-yard).
// Input stream: one infix character per word on s_axis_tdata, s_axis_tlast set on the
// final character of an expression. Output stream: one postfix character per word on
// m_axis_tdata; m_axis_tlast marks the last word caused by an input word,
// m_axis_tuser[0] marks the zero terminator that ends the expression and
// m_axis_tuser[1] is the sticky stack-overflow flag (a push onto a full stack of
// STACK_DEPTH entries was dropped), cleared after the terminator.
// A front end classifies each accepted word into a two-entry command queue; the back
// end owns the operator stack and the output register.
// An operand passes through the command queue and the output register on its way to m_axis.
// Letters, digits, '(' and ignored characters are handled in the idle state alone; ')' and
// operators move to a close or operator state that pops stacked operators one at a time,
// then discards the '(' or pushes the operator; a final word then flushes every stacked
// entry and emits the terminator. Every operator is popped once. The back end's stack
// port does one pop or push per cycle while m_axis_tready does not stall it.
// Reset clears the stack, the queue, the overflow flag and the output valid flag.
// When the receiver holds m_axis_tready low, the back end stops, the queue fills and
// s_axis_tready drops; no word is lost.
module infix_to_postfix_converter_unit
  import i2p_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // in_char
  input  logic       s_axis_tlast,   // end_of_input
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // out_char
  output logic       m_axis_tlast,   // run_last
  output logic [1:0] m_axis_tuser    // [0] expression_done, [1] stack_overflow
);

  logic  wr_valid;
  cmd_t  wr_cmd;
  logic  q_full;
  logic  q_valid;
  logic  q_ready;
  cmd_t  q_cmd;
  stat_t stat;

  i2p_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_full        (q_full),
    .wr_valid      (wr_valid),
    .wr_cmd        (wr_cmd)
  );

  i2p_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (wr_valid),
    .wr_cmd   (wr_cmd),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_cmd   (q_cmd)
  );

  i2p_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (q_valid),
    .cmd_ready     (q_ready),
    .cmd           (q_cmd),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .stat          (stat)
  );

  a_done_is_term: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && m_axis_tdata == CH_TERM)
    else $error("terminator word malformed");

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    stat.count <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tuser[1] && !m_axis_tuser[0]
    |=> !m_axis_tvalid || m_axis_tuser[1])
    else $error("overflow flag dropped before terminator");

  a_idle_no_output: assert property (@(posedge clk) disable iff (rst)
    !stat.busy && !q_valid && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("output word without work");

endmodule

// ----- test/tb_infix_to_postfix_converter_unit.sv -----
module tb_infix_to_postfix_converter_unit;
  import i2p_pkg::*;

  localparam int TARGET_ITEMS = 370;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    bit         hold;   // wait until every expected word has arrived
  } infix_word_t;

  typedef struct {
    logic [7:0] ch;
    logic       run_last;
    logic       done;
    logic       ovf;
  } postfix_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // in_char
  logic       s_axis_tlast = 1'b0;    // end_of_input
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // out_char
  logic       m_axis_tlast;           // run_last
  logic [1:0] m_axis_tuser;           // [0] expression_done, [1] stack_overflow

  infix_word_t   infix_q[$];
  postfix_word_t postfix_q[$];

  // predictor state
  sym_t             op_stack [STACK_DEPTH];
  logic [CNT_W-1:0] stack_cnt = '0;
  bit               ovf_sticky = 1'b0;
  logic [7:0]       emitted[$];

  int errors = 0;
  int words_in = 0;
  int words_out = 0;
  int exprs_done = 0;
  int ovf_words = 0;
  int active_items = 0;
  int send_gap = 0;
  int send_calm = 0;
  int recv_stall = 0;
  int recv_calm = 0;
  int idle_cycles = 0;
  infix_word_t   cur_in;
  postfix_word_t cur_exp;

  infix_to_postfix_converter_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk = ~clk;

  function automatic bit is_operand(logic [7:0] c);
    return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z) ||
           (c >= CH_DIG_0 && c <= CH_DIG_9);
  endfunction

  function automatic bit lookup_op(logic [7:0] c, output sym_t s);
    bit hit;
    hit = 1'b1;
    s = SYM_OPEN;
    case (c)
      CH_POW:  s = SYM_POW;
      CH_MUL:  s = SYM_MUL;
      CH_DIV:  s = SYM_DIV;
      CH_ADD:  s = SYM_ADD;
      CH_SUB:  s = SYM_SUB;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic int unsigned bind_rank(sym_t s);
    case (s)
      SYM_POW:          return 3;
      SYM_MUL, SYM_DIV: return 2;
      SYM_ADD, SYM_SUB: return 1;
      default:          return 0;
    endcase
  endfunction

  function automatic logic [7:0] glyph(sym_t s);
    case (s)
      SYM_OPEN: return CH_OPEN;
      SYM_POW:  return CH_POW;
      SYM_MUL:  return CH_MUL;
      SYM_DIV:  return CH_DIV;
      SYM_ADD:  return CH_ADD;
      SYM_SUB:  return CH_SUB;
      default:  return CH_TERM;
    endcase
  endfunction

  function automatic sym_t top_sym();
    logic [CNT_W-1:0] t;
    t = stack_cnt - 1'b1;
    return op_stack[t[IDX_W-1:0]];
  endfunction

  function automatic void push_sym(sym_t s);
    if (stack_cnt >= STACK_DEPTH) begin
      ovf_sticky = 1'b1;
    end else begin
      op_stack[stack_cnt[IDX_W-1:0]] = s;
      stack_cnt = stack_cnt + 1'b1;
    end
  endfunction

  function automatic void pop_to_output();
    emitted.push_back(glyph(top_sym()));
    stack_cnt = stack_cnt - 1'b1;
  endfunction

  // Shunting-yard step: queue the postfix words caused by one infix word.
  function automatic void convert_char(logic [7:0] c, logic last);
    sym_t          s;
    postfix_word_t w;
    emitted.delete();
    if (is_operand(c)) begin
      emitted.push_back(c);
    end else if (c == CH_OPEN) begin
      push_sym(SYM_OPEN);
    end else if (c == CH_CLOSE) begin
      while (stack_cnt != 0 && top_sym() != SYM_OPEN) pop_to_output();
      if (stack_cnt != 0) stack_cnt = stack_cnt - 1'b1;
    end else if (lookup_op(c, s)) begin
      while (stack_cnt != 0 && top_sym() != SYM_OPEN &&
             bind_rank(top_sym()) >= bind_rank(s)) pop_to_output();
      push_sym(s);
    end
    if (last) begin
      while (stack_cnt != 0) pop_to_output();
      emitted.push_back(CH_TERM);
      exprs_done++;
    end
    foreach (emitted[i]) begin
      w.ch = emitted[i];
      w.run_last = (i == emitted.size() - 1);
      w.done = last && (i == emitted.size() - 1);
      w.ovf = ovf_sticky;
      postfix_q.push_back(w);
    end
    if (last) ovf_sticky = 1'b0;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 9);
    return $urandom_range(20, 40);
  endfunction

  task automatic add_word(logic [7:0] c, logic last, bit hold);
    infix_word_t w;
    sym_t        s;
    w.ch = c;
    w.last = last;
    w.hold = hold;
    infix_q.push_back(w);
    if (is_operand(c) || c == CH_OPEN || c == CH_CLOSE || lookup_op(c, s) || last)
      active_items++;
  endtask

  task automatic add_expr(logic [7:0] seq[$], bit hold);
    foreach (seq[i]) add_word(seq[i], i == seq.size() - 1, hold && i == 0);
  endtask

  function automatic logic [7:0] rand_operand();
    case ($urandom_range(0, 2))
      0:       return 8'($urandom_range(CH_UP_A, CH_UP_Z));
      1:       return 8'($urandom_range(CH_LO_A, CH_LO_Z));
      default: return 8'($urandom_range(CH_DIG_0, CH_DIG_9));
    endcase
  endfunction

  function automatic logic [7:0] rand_op();
    case ($urandom_range(0, 4))
      0:       return CH_POW;
      1:       return CH_MUL;
      2:       return CH_DIV;
      3:       return CH_ADD;
      default: return CH_SUB;
    endcase
  endfunction

  // Balanced expression with random operands, operators and nesting.
  task automatic gen_balanced(bit hold);
    logic [7:0] seq[$];
    int n_opnd, depth, n;
    n_opnd = $urandom_range(1, 7);
    depth = 0;
    for (int k = 0; k < n_opnd; k++) begin
      n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
      for (int j = 0; j < n && depth < 8; j++) begin
        seq.push_back(CH_OPEN);
        depth++;
      end
      seq.push_back(rand_operand());
      if (depth > 0 && $urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, depth);
        repeat (n) seq.push_back(CH_CLOSE);
        depth -= n;
      end
      if (k < n_opnd - 1) seq.push_back(rand_op());
    end
    repeat (depth) seq.push_back(CH_CLOSE);
    add_expr(seq, hold);
  endtask

  // Nesting around and past the stack depth, so pushes get dropped in most cases.
  task automatic gen_deep();
    logic [7:0] seq[$];
    int n;
    n = $urandom_range(30, 40);
    repeat (n) seq.push_back(CH_OPEN);
    seq.push_back(rand_operand());
    repeat ($urandom_range(0, 3)) begin
      seq.push_back(rand_op());
      seq.push_back(rand_operand());
    end
    repeat ($urandom_range(0, 6)) seq.push_back(CH_CLOSE);
    if ($urandom_range(0, 1) == 0) seq.push_back(rand_operand());
    add_expr(seq, 1'b0);
  endtask

  // Broken token soup, stray bytes included.
  task automatic gen_broken();
    logic [7:0] seq[$];
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 4))
        0:       seq.push_back(rand_operand());
        1:       seq.push_back(rand_op());
        2:       seq.push_back(CH_OPEN);
        3:       seq.push_back(CH_CLOSE);
        default: seq.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    add_expr(seq, 1'b0);
  endtask

  task automatic fill_stimulus();
    int r;
    // precedence, left-assoc ^, operators - / ^, digits
    add_expr('{CH_OPEN, "A", CH_SUB, "B", CH_CLOSE, CH_DIV, "z", CH_POW, "0", CH_POW, "9"},
             1'b0);
    // unmatched ')' with operators below it
    add_expr('{"a", CH_ADD, "b", CH_MUL, "c", CH_CLOSE, "d"}, 1'b0);
    // unmatched '(' flushed at the end, ignored extremes of the byte range
    add_expr('{CH_OPEN, 8'h00, CH_OPEN, "x", 8'hFF}, 1'b0);
    gen_balanced(1'b1);
    while (active_items < TARGET_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 72) gen_balanced(active_items > TARGET_ITEMS / 2 && r < 4);
      else if (r < 77) gen_deep();
      else gen_broken();
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'h00;
      s_axis_tlast  <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        convert_char(s_axis_tdata, s_axis_tlast);
        words_in++;
        if (send_calm > 0) send_calm--;
        else if ($urandom_range(0, 39) == 0) send_calm = $urandom_range(20, 60);
        send_gap = (send_calm > 0) ? 0 : pick_gap();
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (infix_q.size() != 0 && (!infix_q[0].hold || postfix_q.size() == 0)) begin
          cur_in = infix_q.pop_front();
          s_axis_tdata  <= cur_in.ch;
          s_axis_tlast  <= cur_in.last;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        words_out++;
        if (postfix_q.size() == 0) begin
          $error("unexpected output word: out_char %0h", m_axis_tdata);
          errors++;
        end else begin
          cur_exp = postfix_q.pop_front();
          if (m_axis_tdata !== cur_exp.ch) begin
            $error("out_char: expected %0h, got %0h", cur_exp.ch, m_axis_tdata);
            errors++;
          end
          if (m_axis_tlast !== cur_exp.run_last) begin
            $error("run_last: expected %0b, got %0b", cur_exp.run_last, m_axis_tlast);
            errors++;
          end
          if (m_axis_tuser[0] !== cur_exp.done) begin
            $error("expression_done: expected %0b, got %0b", cur_exp.done, m_axis_tuser[0]);
            errors++;
          end
          if (m_axis_tuser[1] !== cur_exp.ovf) begin
            $error("stack_overflow: expected %0b, got %0b", cur_exp.ovf, m_axis_tuser[1]);
            errors++;
          end
          if (cur_exp.ovf) ovf_words++;
        end
      end
      if (recv_calm > 0) recv_calm--;
      else if ($urandom_range(0, 149) == 0) recv_calm = $urandom_range(30, 80);
      if (recv_stall > 0) begin
        recv_stall--;
        m_axis_tready <= 1'b0;
      end else if (recv_calm == 0 && $urandom_range(0, 3) == 0) begin
        recv_stall = pick_gap();
        m_axis_tready <= (recv_stall == 0);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog: cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("[infix_to_postfix_converter_unit] ERROR");
      $finish;
    end
  end

  initial begin
    fill_stimulus();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    while (infix_q.size() != 0 || s_axis_tvalid || postfix_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (postfix_q.size() != 0) begin
      $error("%0d expected output words never arrived", postfix_q.size());
      errors++;
    end
    $display("Converted %0d expressions: %0d input words, %0d output words.",
             exprs_done, words_in, words_out);
    $display("Balanced, deeply nested (overflowing) and broken input; %0d overflow-flagged words.",
             ovf_words);
    if (errors == 0)
      $display("[infix_to_postfix_converter_unit] OK");
    else
      $display("[infix_to_postfix_converter_unit] ERROR");
    $finish;
  end

endmodule
